// ===== hdl/gscc_pkg.sv =====
// Package: item types, register map and thresholds for the growth stage climate controller.
`default_nettype none

package gscc_pkg;

  localparam int unsigned TimeW = 32;

  localparam int unsigned AddrW = 4;

  localparam logic [1:0] RegAutoEnable   = 2'd0;
  localparam logic [1:0] RegWaterDur     = 2'd1;
  localparam logic [1:0] RegSeedInterval = 2'd2;
  localparam logic [1:0] RegVegInterval  = 2'd3;

  localparam logic [TimeW-1:0] WaterDurReset     = TimeW'(20000);
  localparam logic [TimeW-1:0] SeedIntervalReset = TimeW'(10800000);
  localparam logic [TimeW-1:0] VegIntervalReset  = TimeW'(7200000);

  localparam logic       CmdUpdate   = 1'b0;
  localparam logic       CmdSetStage = 1'b1;

  localparam logic [2:0] StageGerm  = 3'd1;
  localparam logic [2:0] StageSeed  = 3'd2;
  localparam logic [2:0] StageVeg   = 3'd3;
  localparam logic [2:0] StageFlower = 3'd4;

  // humidity, tenths of a percent
  localparam logic [9:0] GermMistOn   = 10'd550;
  localparam logic [9:0] GermMistOff  = 10'd650;
  localparam logic [9:0] SeedMistOn   = 10'd600;
  localparam logic [9:0] SeedMistOff  = 10'd750;
  localparam logic [9:0] VegMistOn    = 10'd750;
  localparam logic [9:0] VegMistOff   = 10'd850;
  // soil moisture, percent
  localparam logic [6:0] SeedPumpOn   = 7'd35;
  localparam logic [6:0] SeedPumpOff  = 7'd65;
  localparam logic [6:0] VegPumpOn    = 7'd55;
  localparam logic [6:0] VegPumpOff   = 7'd85;
  // temperature, tenths of a degree C
  localparam logic signed [11:0] VegFanOn  = 12'sd280;
  localparam logic signed [11:0] VegFanOff = 12'sd250;

  typedef struct packed {
    logic              cmd;
    logic [TimeW-1:0]  now_ms;
    logic signed [11:0] temperature;
    logic [9:0]        humidity;
    logic [6:0]        soil_moisture;
    logic              light_on;
    logic [2:0]        new_stage;
  } in_t;

  typedef struct packed {
    logic       pump_on;
    logic       mist_on;
    logic       fan_on;
    logic       light_off;
    logic       watering_active;
    logic [2:0] stage_now;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/growth_stage_climate_controller.sv =====
// Top level: growth stage climate controller with APB configuration and item pipeline.
//
// Items pass through an input register and a result register, one item per cycle
// sustained while out_ready_i is high; a result is loaded into the result register
// when its item advances out of the input register, which a stall can delay. The relay
// state is updated at the edge that loads the result register, so the next item
// already sees it. Configuration registers sit on an APB port (byte addresses 0x0
// auto_enable, 0x4 water_duration_ms, 0x8 seedling_interval_ms, 0xC
// vegetative_interval_ms), pready always high; write them only while the block
// holds no item. Elapsed times wrap modulo 2^32.
`default_nettype none

module growth_stage_climate_controller
  import gscc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_data_o
);

  // configuration
  logic             auto_en_q;
  logic [TimeW-1:0] water_dur_q, seed_int_q, veg_int_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_en_q   <= 1'b1;
      water_dur_q <= WaterDurReset;
      seed_int_q  <= SeedIntervalReset;
      veg_int_q   <= VegIntervalReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegAutoEnable:   auto_en_q   <= pwdata[0];
        RegWaterDur:     water_dur_q <= pwdata;
        RegSeedInterval: seed_int_q  <= pwdata;
        RegVegInterval:  veg_int_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegAutoEnable:   prdata = {31'd0, auto_en_q};
      RegWaterDur:     prdata = water_dur_q;
      RegSeedInterval: prdata = seed_int_q;
      RegVegInterval:  prdata = veg_int_q;
      default:         prdata = '0;
    endcase
  end

  // pipeline
  logic in_valid_q, out_valid_q, advance;
  in_t  in_q;
  out_t out_q;
  out_t out_d;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance) out_q <= out_d;
  end

  // controller state
  logic [2:0]       stage_q, stage_d;
  logic             pump_q, pump_d, mist_q, mist_d, fan_q, fan_d;
  logic             water_q, water_d;
  logic [TimeW-1:0] last_q, last_d, start_q, start_d;
  logic             light_off;
  logic [TimeW-1:0] since_start, since_last;

  assign since_start = in_q.now_ms - start_q;
  assign since_last  = in_q.now_ms - last_q;

  always_comb begin
    stage_d   = stage_q;
    pump_d    = pump_q;
    mist_d    = mist_q;
    fan_d     = fan_q;
    water_d   = water_q;
    last_d    = last_q;
    start_d   = start_q;
    light_off = 1'b0;
    if (in_q.cmd == CmdSetStage) begin
      if (in_q.new_stage >= StageGerm && in_q.new_stage <= StageFlower) begin
        stage_d   = in_q.new_stage;
        light_off = 1'b1;
        pump_d    = 1'b0;
        mist_d    = 1'b0;
        fan_d     = 1'b0;
        water_d   = 1'b0;
        last_d    = in_q.now_ms;
      end
    end else if (auto_en_q) begin
      if (water_q) begin
        if (since_start >= water_dur_q) begin
          pump_d  = 1'b0;
          water_d = 1'b0;
          last_d  = in_q.now_ms;
        end
      end else begin
        case (stage_q)
          StageGerm: begin
            light_off = 1'b1;
            pump_d    = 1'b0;
            if (in_q.humidity < GermMistOn) mist_d = 1'b1;
            else if (in_q.humidity > GermMistOff) mist_d = 1'b0;
          end
          StageSeed: begin
            if (in_q.light_on && since_last >= seed_int_q) begin
              pump_d  = 1'b1;
              water_d = 1'b1;
              start_d = in_q.now_ms;
            end else begin
              if (in_q.soil_moisture < SeedPumpOn) pump_d = 1'b1;
              else if (in_q.soil_moisture > SeedPumpOff) pump_d = 1'b0;
              if (in_q.humidity < SeedMistOn) mist_d = 1'b1;
              else if (in_q.humidity > SeedMistOff) mist_d = 1'b0;
            end
          end
          StageVeg: begin
            if (since_last >= veg_int_q) begin
              pump_d  = 1'b1;
              water_d = 1'b1;
              start_d = in_q.now_ms;
            end else begin
              if (in_q.soil_moisture < VegPumpOn) pump_d = 1'b1;
              else if (in_q.soil_moisture > VegPumpOff) pump_d = 1'b0;
              if (in_q.humidity < VegMistOn) mist_d = 1'b1;
              else if (in_q.humidity > VegMistOff) mist_d = 1'b0;
              if (in_q.temperature > VegFanOn && in_q.light_on) fan_d = 1'b1;
              else if (in_q.temperature < VegFanOff || !in_q.light_on) fan_d = 1'b0;
            end
          end
          StageFlower: pump_d = 1'b0;
          default: ;
        endcase
      end
    end
    out_d.pump_on         = pump_d;
    out_d.mist_on         = mist_d;
    out_d.fan_on          = fan_d;
    out_d.light_off       = light_off;
    out_d.watering_active = water_d;
    out_d.stage_now       = stage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StageGerm;
      pump_q  <= 1'b0;
      mist_q  <= 1'b0;
      fan_q   <= 1'b0;
      water_q <= 1'b0;
      last_q  <= '0;
      start_q <= '0;
    end else if (advance) begin
      stage_q <= stage_d;
      pump_q  <= pump_d;
      mist_q  <= mist_d;
      fan_q   <= fan_d;
      water_q <= water_d;
      last_q  <= last_d;
      start_q <= start_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_water_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    water_q |-> pump_q) else $error("timed watering without pump");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q >= StageGerm && stage_q <= StageFlower) else $error("stage out of range");

  a_water_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.watering_active |-> out_q.stage_now == StageSeed ||
    out_q.stage_now == StageVeg) else $error("watering outside stages 2 and 3");

  a_light_water: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.light_off |-> !out_q.watering_active)
    else $error("light off during watering");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(stage_q) && $stable(water_q) && $stable(last_q))
    else $error("state moved without an item");

endmodule

`default_nettype wire
